// ===== hw/rtl/ebsgs_pkg.sv =====
// ---------------------------------------------------------------------------
// ebsgs_pkg
// Shared types and constants of the extended baby-step giant-step solver.
// ---------------------------------------------------------------------------
package ebsgs_pkg;

    localparam int IN_W    = 32;
    localparam int LOG_W   = 33;
    localparam int EPOCH_W = 8;

    // multiplicative hash: slot = bits above HASH_SHIFT of key * golden ratio
    localparam int          HASH_SHIFT  = 20;
    localparam int          HASH_SPLIT  = 21;
    localparam int          HASH_PW     = 2 * HASH_SPLIT;
    localparam logic [63:0] HASH_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [HASH_SPLIT-1:0] HASH_C_LO = HASH_GOLDEN[HASH_SPLIT-1:0];
    localparam logic [HASH_SPLIT-1:0] HASH_C_HI = HASH_GOLDEN[HASH_PW-1:HASH_SPLIT];

    typedef enum logic [5:0] {
        S_IDLE, S_NEWQ, S_NEWQ_W, S_RED_A, S_RED_B, S_GCD, S_GCD_R, S_GCHK_R,
        S_DIV_M_R, S_DIV_B_R, S_DIV_A_R, S_FIX_R, S_RED_A2_R, S_SQ_ALIGN,
        S_SQ_STEP, S_SQ_FIX, S_BABY_PUT, S_BABY_W, S_BABY_R, S_POW, S_POW_R1,
        S_POW_R2, S_GP_R, S_GIANT_GET, S_GIANT_W, S_GIANT_R, S_X_SUB, S_DONE,
        S_MUL, S_DIV, S_DIV_W
    } t_state;

    typedef enum logic [2:0] {
        SS_CLR, SS_IDLE, SS_H1, SS_H2, SS_H3, SS_RD, SS_CHK
    } t_st_state;

    typedef enum logic [1:0] {
        SOP_NEWQ, SOP_PUT, SOP_GET
    } t_store_op;

    typedef struct packed {
        logic      start;
        t_store_op op;
    } t_store_ctl;

    typedef struct packed {
        logic ready;
        logic done;
        logic hit;
    } t_store_sts;

endpackage

// ===== hw/rtl/ebsgs_div.sv =====
// ---------------------------------------------------------------------------
// ebsgs_div
// Restoring divider, one quotient bit per cycle, quotient and remainder held.
// ---------------------------------------------------------------------------
module ebsgs_div import ebsgs_pkg::*; #(
    parameter int VW = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [2*VW-1:0] i_dividend,
    input  logic [VW-1:0]   i_divisor,
    output logic            o_done,
    output logic [2*VW-1:0] o_quot,
    output logic [VW-1:0]   o_rem
);
    localparam int DW = 2 * VW;
    localparam int CW = $clog2(DW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem, r_d;
    logic [VW:0]   trial, diff;
    logic          ge;

    assign trial = {r_rem, r_q[DW-1]};
    assign ge    = trial >= {1'b0, r_d};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_q   <= {r_q[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

// ===== hw/rtl/ebsgs_store.sv =====
// ---------------------------------------------------------------------------
// ebsgs_store
// Linear-probing hash store in one synchronous memory; occupancy by epoch tag.
// ---------------------------------------------------------------------------
module ebsgs_store import ebsgs_pkg::*; #(
    parameter int VW          = 32,
    parameter int SB          = 17,
    parameter int TABLE_DEPTH = 131072
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_store_ctl    i_ctl,
    input  logic [VW-1:0] i_key,
    input  logic [SB-1:0] i_step,
    output t_store_sts    o_sts,
    output logic [SB-1:0] o_step
);
    localparam int AB = $clog2(TABLE_DEPTH);
    localparam int WW = EPOCH_W + VW + SB;

    logic [WW-1:0] r_mem [TABLE_DEPTH];
    logic [WW-1:0] r_rd;

    t_st_state r_state, n_state;
    t_store_op r_op;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic               r_wrap, n_wrap;
    logic [AB-1:0]      r_addr, n_addr, r_probe, n_probe;
    logic               r_done, n_done, r_hit, n_hit;
    logic [VW-1:0]      r_key;
    logic [SB-1:0]      r_step, r_step_out;
    logic [HASH_PW-1:0] r_plo, r_phi, hsum;
    logic [IN_W-1:0]    keyx;

    logic          w_en;
    logic [WW-1:0] w_data;
    logic          occ, match, last;
    logic [EPOCH_W-1:0] rd_epoch;
    logic [VW-1:0]      rd_key;
    logic [SB-1:0]      rd_step;

    assign keyx     = IN_W'(r_key);
    assign hsum     = r_plo + (r_phi << HASH_SPLIT);
    assign rd_epoch = r_rd[WW-1 -: EPOCH_W];
    assign rd_key   = r_rd[SB +: VW];
    assign rd_step  = r_rd[SB-1:0];
    assign occ      = rd_epoch == r_epoch;
    assign match    = rd_key == r_key;
    assign last     = r_probe == '1;

    // next state
    always_comb begin
        n_state = r_state;
        n_epoch = r_epoch;
        n_wrap  = r_wrap;
        n_addr  = r_addr;
        n_probe = r_probe;
        n_done  = 1'b0;
        n_hit   = r_hit;
        case (r_state)
            SS_CLR: begin
                n_addr = r_addr + AB'(1);
                if (r_addr == '1) begin
                    n_state = SS_IDLE;
                    n_epoch = r_wrap ? EPOCH_W'(1) : '0;
                    n_done  = r_wrap;
                    n_wrap  = 1'b0;
                end
            end
            SS_IDLE: begin
                if (i_ctl.start) begin
                    if (i_ctl.op == SOP_NEWQ) begin
                        if (r_epoch == '1) begin
                            n_state = SS_CLR;
                            n_wrap  = 1'b1;
                            n_addr  = '0;
                        end else begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                            n_done  = 1'b1;
                        end
                    end else begin
                        n_state = SS_H1;
                    end
                end
            end
            SS_H1: n_state = SS_H2;
            SS_H2: n_state = SS_H3;
            SS_H3: begin
                n_addr  = hsum[HASH_SHIFT +: AB];
                n_probe = '0;
                n_state = SS_RD;
            end
            SS_RD: n_state = SS_CHK;
            SS_CHK: begin
                if (!occ || match || last) begin
                    n_state = SS_IDLE;
                    n_done  = 1'b1;
                    n_hit   = occ && match;
                end else begin
                    n_addr  = r_addr + AB'(1);
                    n_probe = r_probe + AB'(1);
                    n_state = SS_RD;
                end
            end
            default: n_state = SS_IDLE;
        endcase
    end

    // memory write strobe
    always_comb begin
        w_en   = 1'b0;
        w_data = {r_epoch, r_key, r_step};
        case (r_state)
            SS_CLR: begin
                w_en   = 1'b1;
                w_data = '0;
            end
            SS_CHK: w_en = (r_op == SOP_PUT) && (!occ || match);
            default: w_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[r_addr] <= w_data;
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_CLR;
            r_epoch <= '0;
            r_wrap  <= 1'b0;
            r_addr  <= '0;
            r_probe <= '0;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_epoch <= n_epoch;
            r_wrap  <= n_wrap;
            r_addr  <= n_addr;
            r_probe <= n_probe;
            r_done  <= n_done;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == SS_IDLE && i_ctl.start) begin
            r_op   <= i_ctl.op;
            r_key  <= i_key;
            r_step <= i_step;
        end
        if (r_state == SS_H1) r_plo <= HASH_PW'(keyx * HASH_C_LO);
        if (r_state == SS_H2) r_phi <= HASH_PW'(keyx * HASH_C_HI);
        if (r_state == SS_CHK && occ && match) r_step_out <= rd_step;
    end

    assign o_sts.ready = r_state == SS_IDLE;
    assign o_sts.done  = r_done;
    assign o_sts.hit   = r_hit;
    assign o_step      = r_step_out;
endmodule

// ===== hw/rtl/extended_bsgs_discrete_log.sv =====
// ---------------------------------------------------------------------------
// extended_bsgs_discrete_log
// Discrete logarithm a^x = b (mod m) by extended baby-step giant-step.
// ---------------------------------------------------------------------------
// One transaction in carries base, target and modulus; one transaction out
// carries the found flag and x. Items are solved one at a time. Every modular
// multiply is a registered product followed by a bit-serial reduction in the
// shared divider, which also serves each gcd step and each division. A hash
// access hashes the key in three states, then reads and checks one slot per
// probe through the single-port store. A query costs roughly k baby steps and
// up to k giant steps with k = ceil(sqrt(m)); trivial cases (target one,
// early exits) skip the search. After reset, and again each time the epoch
// tag wraps (the 256th query after reset, then every 255th), the store runs
// a clearing pass over all TABLE_DEPTH entries before the query goes on.
// TABLE_DEPTH must be a power of two.
// ---------------------------------------------------------------------------
module extended_bsgs_discrete_log import ebsgs_pkg::*; #(
    parameter int MOD_BITS    = 32,
    parameter int TABLE_DEPTH = 131072
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // base_value, target_value, modulus
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // log_value, zero fill
    output logic [0:0]  o_m_tuser    // found
);
    // working value width: inputs never carry more than 32 bits
    localparam int VW     = (MOD_BITS < IN_W) ? MOD_BITS : IN_W;
    localparam int DW     = 2 * VW;
    localparam int KW     = VW / 2 + 1;          // k = ceil(sqrt(m)) and steps
    localparam int XW     = 2 * KW + 1;
    localparam int SHW    = $clog2(VW + 1);
    localparam int SQ_TOP = ((VW - 1) / 2) * 2;  // top power of four

    t_state r_state, n_state, r_ret, n_ret;

    logic [VW-1:0]  r_a, n_a, r_b, n_b, r_m, n_m, r_fix, n_fix;
    logic [VW-1:0]  r_gx, n_gx, r_gy, n_gy, r_g, n_g;
    logic [VW-1:0]  r_q, n_q, r_w, n_w, r_pr, n_pr, r_px, n_px, r_p, n_p;
    logic [VW-1:0]  r_mx, n_mx, r_my, n_my;
    logic [VW-1:0]  r_sq_n, n_sq_n, r_sq_r, n_sq_r, r_sq_bit, n_sq_bit;
    logic [SHW-1:0] r_shift, n_shift;
    logic [KW-1:0]  r_k, n_k, r_j, n_j, r_pe, n_pe, r_i, n_i;
    logic [2*KW-1:0] r_xm, n_xm;
    logic [DW-1:0]  r_dn, n_dn;
    logic [VW-1:0]  r_dd, n_dd;

    logic             r_ov, n_ov, r_found, n_found;
    logic [LOG_W-1:0] r_x, n_x;
    logic             r_ans_found, n_ans_found;
    logic [LOG_W-1:0] r_ans_x, n_ans_x;
    logic             ans, ans_found;
    logic [LOG_W-1:0] ans_x;

    logic [VW:0]     sq_sum;
    logic [DW-1:0]   sq_sq;

    logic            div_start, div_done;
    logic [DW-1:0]   div_quot;
    logic [VW-1:0]   div_rem;

    t_store_ctl      st_ctl;
    t_store_sts      st_sts;
    logic [VW-1:0]   st_key;
    logic [KW-1:0]   st_step_in, st_step;

    logic            s_acc;

    assign s_acc  = i_s_tvalid && o_s_tready;
    assign sq_sum = {1'b0, r_sq_r} + {1'b0, r_sq_bit};
    assign sq_sq  = r_sq_r * r_sq_r;

    ebsgs_div #(.VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_dn),
        .i_divisor  (r_dd),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    ebsgs_store #(.VW(VW), .SB(KW), .TABLE_DEPTH(TABLE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (st_ctl),
        .i_key   (st_key),
        .i_step  (st_step_in),
        .o_sts   (st_sts),
        .o_step  (st_step)
    );

    // next state and datapath
    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_a = r_a;  n_b = r_b;  n_m = r_m;  n_fix = r_fix;
        n_gx = r_gx;  n_gy = r_gy;  n_g = r_g;
        n_q = r_q;  n_w = r_w;  n_pr = r_pr;  n_px = r_px;  n_p = r_p;
        n_mx = r_mx;  n_my = r_my;
        n_sq_n = r_sq_n;  n_sq_r = r_sq_r;  n_sq_bit = r_sq_bit;
        n_shift = r_shift;  n_k = r_k;  n_j = r_j;  n_pe = r_pe;  n_i = r_i;
        n_xm = r_xm;  n_dn = r_dn;  n_dd = r_dd;
        ans = 1'b0;  ans_found = 1'b0;  ans_x = '0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_a = i_s_tdata[VW-1:0];
                    n_b = i_s_tdata[32 +: VW];
                    n_m = i_s_tdata[64 +: VW];
                    n_state = S_NEWQ;
                end
            end
            S_NEWQ: if (st_sts.ready) n_state = S_NEWQ_W;
            S_NEWQ_W: begin
                if (st_sts.done) begin
                    if (r_m == '0) begin
                        ans = 1'b1;
                    end else begin
                        n_dn = DW'(r_a);  n_dd = r_m;  n_ret = S_RED_A;
                        n_state = S_DIV;
                    end
                end
            end
            S_RED_A: begin
                n_a = div_rem;
                n_dn = DW'(r_b);  n_dd = r_m;  n_ret = S_RED_B;
                n_state = S_DIV;
            end
            S_RED_B: begin
                n_b = div_rem;
                if (div_rem == VW'(1)) begin
                    ans = 1'b1;  ans_found = 1'b1;
                end else begin
                    n_gx = r_a;  n_gy = r_m;  n_shift = '0;  n_fix = VW'(1);
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_gy == '0) begin
                    n_g = r_gx;
                    n_state = S_DIV;
                    if (r_gx == VW'(1)) begin
                        n_dn = DW'(r_a);  n_dd = r_m;  n_ret = S_RED_A2_R;
                    end else begin
                        n_dn = DW'(r_b);  n_dd = r_gx;  n_ret = S_GCHK_R;
                    end
                end else begin
                    n_dn = DW'(r_gx);  n_dd = r_gy;  n_ret = S_GCD_R;
                    n_state = S_DIV;
                end
            end
            S_GCD_R: begin
                n_gx = r_gy;  n_gy = div_rem;
                n_state = S_GCD;
            end
            S_GCHK_R: begin
                if (div_rem != '0) begin
                    ans = 1'b1;
                end else begin
                    n_dn = DW'(r_m);  n_dd = r_g;  n_ret = S_DIV_M_R;
                    n_state = S_DIV;
                end
            end
            S_DIV_M_R: begin
                n_m = div_quot[VW-1:0];
                n_dn = DW'(r_b);  n_dd = r_g;  n_ret = S_DIV_B_R;
                n_state = S_DIV;
            end
            S_DIV_B_R: begin
                n_b = div_quot[VW-1:0];
                n_dn = DW'(r_a);  n_dd = r_g;  n_ret = S_DIV_A_R;
                n_state = S_DIV;
            end
            S_DIV_A_R: begin
                n_shift = r_shift + SHW'(1);
                n_mx = r_fix;  n_my = div_quot[VW-1:0];  n_ret = S_FIX_R;
                n_state = S_MUL;
            end
            S_FIX_R: begin
                n_fix = div_rem;
                if (div_rem == r_b) begin
                    ans = 1'b1;  ans_found = 1'b1;  ans_x = LOG_W'(r_shift);
                end else begin
                    n_gx = r_a;  n_gy = r_m;
                    n_state = S_GCD;
                end
            end
            S_RED_A2_R: begin
                n_a = div_rem;
                n_sq_n = r_m;  n_sq_r = '0;  n_sq_bit = VW'(1) << SQ_TOP;
                n_state = S_SQ_ALIGN;
            end
            S_SQ_ALIGN: begin
                if (r_sq_bit > r_sq_n) n_sq_bit = r_sq_bit >> 2;
                else n_state = S_SQ_STEP;
            end
            S_SQ_STEP: begin
                if (r_sq_bit == '0) begin
                    n_state = S_SQ_FIX;
                end else begin
                    if ({1'b0, r_sq_n} >= sq_sum) begin
                        n_sq_n = r_sq_n - sq_sum[VW-1:0];
                        n_sq_r = (r_sq_r >> 1) + r_sq_bit;
                    end else begin
                        n_sq_r = r_sq_r >> 1;
                    end
                    n_sq_bit = r_sq_bit >> 2;
                end
            end
            S_SQ_FIX: begin
                n_k = (sq_sq < DW'(r_m)) ? KW'(r_sq_r + VW'(1)) : KW'(r_sq_r);
                n_j = '0;  n_q = r_b;
                n_state = S_BABY_PUT;
            end
            S_BABY_PUT: n_state = S_BABY_W;
            S_BABY_W: begin
                if (st_sts.done) begin
                    if (({1'b0, r_j} + (KW+1)'(1)) == {1'b0, r_k}) begin
                        n_pr = (r_m == VW'(1)) ? '0 : VW'(1);
                        n_px = r_a;  n_pe = r_k;
                        n_state = S_POW;
                    end else begin
                        n_mx = r_q;  n_my = r_a;  n_ret = S_BABY_R;
                        n_state = S_MUL;
                    end
                end
            end
            S_BABY_R: begin
                n_q = div_rem;  n_j = r_j + KW'(1);
                n_state = S_BABY_PUT;
            end
            S_POW: begin
                n_state = S_MUL;
                if (r_pe == '0) begin
                    n_w = r_pr;  n_mx = r_pr;  n_my = r_fix;  n_ret = S_GP_R;
                end else if (r_pe[0]) begin
                    n_mx = r_pr;  n_my = r_px;  n_ret = S_POW_R1;
                end else begin
                    n_mx = r_px;  n_my = r_px;  n_ret = S_POW_R2;
                end
            end
            S_POW_R1: begin
                n_pr = div_rem;
                n_mx = r_px;  n_my = r_px;  n_ret = S_POW_R2;
                n_state = S_MUL;
            end
            S_POW_R2: begin
                n_px = div_rem;  n_pe = r_pe >> 1;
                n_state = S_POW;
            end
            S_GP_R: begin
                n_p = div_rem;  n_i = KW'(1);
                n_state = S_GIANT_GET;
            end
            S_GIANT_GET: n_state = S_GIANT_W;
            S_GIANT_W: begin
                if (st_sts.done) begin
                    if (st_sts.hit) begin
                        n_xm = r_i * r_k;
                        n_state = S_X_SUB;
                    end else if (r_i == r_k) begin
                        ans = 1'b1;
                    end else begin
                        n_mx = r_p;  n_my = r_w;  n_ret = S_GIANT_R;
                        n_state = S_MUL;
                    end
                end
            end
            S_GIANT_R: begin
                n_p = div_rem;  n_i = r_i + KW'(1);
                n_state = S_GIANT_GET;
            end
            S_X_SUB: begin
                ans = 1'b1;  ans_found = 1'b1;
                ans_x = LOG_W'(XW'(r_xm) - XW'(st_step) + XW'(r_shift));
            end
            S_MUL: begin
                n_dn = r_mx * r_my;  n_dd = r_m;
                n_state = S_DIV;
            end
            S_DIV: n_state = S_DIV_W;
            S_DIV_W: if (div_done) n_state = r_ret;
            S_DONE: if (!r_ov || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (ans) n_state = S_DONE;
    end

    // result register: hold the pending answer until the output stage frees
    always_comb begin
        n_ov        = r_ov;
        n_found     = r_found;
        n_x         = r_x;
        n_ans_found = r_ans_found;
        n_ans_x     = r_ans_x;
        if (r_ov && i_m_tready) n_ov = 1'b0;
        if (ans) begin
            n_ans_found = ans_found;
            n_ans_x     = ans_x;
        end
        if (r_state == S_DONE && (!r_ov || i_m_tready)) begin
            n_ov    = 1'b1;
            n_found = r_ans_found;
            n_x     = r_ans_x;
        end
    end

    // outputs and unit strobes
    always_comb begin
        o_s_tready = r_state == S_IDLE;
        div_start  = r_state == S_DIV;
        st_ctl.start = 1'b0;
        st_ctl.op    = SOP_NEWQ;
        st_key       = r_q;
        st_step_in   = r_j;
        case (r_state)
            S_NEWQ: st_ctl.start = st_sts.ready;
            S_BABY_PUT: begin
                st_ctl.start = 1'b1;
                st_ctl.op    = SOP_PUT;
            end
            S_GIANT_GET: begin
                st_ctl.start = 1'b1;
                st_ctl.op    = SOP_GET;
                st_key       = r_p;
            end
            default: st_ctl.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_a <= n_a;  r_b <= n_b;  r_m <= n_m;  r_fix <= n_fix;
        r_gx <= n_gx;  r_gy <= n_gy;  r_g <= n_g;
        r_q <= n_q;  r_w <= n_w;  r_pr <= n_pr;  r_px <= n_px;  r_p <= n_p;
        r_mx <= n_mx;  r_my <= n_my;
        r_sq_n <= n_sq_n;  r_sq_r <= n_sq_r;  r_sq_bit <= n_sq_bit;
        r_shift <= n_shift;  r_k <= n_k;  r_j <= n_j;  r_pe <= n_pe;  r_i <= n_i;
        r_xm <= n_xm;  r_dn <= n_dn;  r_dd <= n_dd;
        r_found <= n_found;  r_x <= n_x;
        r_ans_found <= n_ans_found;  r_ans_x <= n_ans_x;
    end

    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = {7'b0, r_x};
    assign o_m_tuser[0] = r_found;

    // a miss always reports a zero exponent
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 40'd0)
        else $error("miss with nonzero log_value");

    // the divider never sees a zero divisor
    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_dd != '0)
        else $error("divide by zero issued");

    // store commands only go to an idle store
    a_st_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.start |-> st_sts.ready)
        else $error("store command while busy");

    // an accepted transaction opens a new query epoch next
    a_acc_newq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_state == S_NEWQ)
        else $error("accept did not start a query");
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the extended baby-step giant-step discrete log.
// ---------------------------------------------------------------------------
// Queries are sent as stream transactions. A short table of directed queries
// comes first. Some of its rows carry an expected answer typed in by hand,
// and the rest are worked out by a behavioural solver in this file. Random
// queries follow. Most of them use small moduli so that each solve stays
// short. A few use large moduli that leave the solver early. Both sides
// idle at random. Once, the result side holds off for a long stretch so
// that the block backs up and stalls its input.
// ---------------------------------------------------------------------------
module tb;
    import ebsgs_pkg::*;

    typedef struct {
        logic [31:0] base_v;
        logic [31:0] tgt_v;
        logic [31:0] mod_v;
        bit          typed;    // expected answer given in the row
        bit          found;
        logic [32:0] log_v;
    } t_query;

    typedef struct {
        bit          found;
        logic [32:0] log_v;
    } t_answer;

    localparam int N_RANDOM = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata = '0;   // base_value, target_value, modulus
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;        // log_value, zero fill
    logic [0:0]  o_m_tuser;        // found

    t_answer pending_logs[$];
    int      fail_cnt = 0;
    bit      send_done = 0;

    always #1 i_clk = ~i_clk;

    extended_bsgs_discrete_log DUT (.*);

    // ------------------------------------------------------------------
    // Behavioural solver
    // ------------------------------------------------------------------
    function automatic longint unsigned mulmod(longint unsigned x,
                                               longint unsigned y,
                                               longint unsigned m);
        return ((x % m) * (y % m)) % m;
    endfunction

    function automatic longint unsigned powmod(longint unsigned x,
                                               longint unsigned e,
                                               longint unsigned m);
        longint unsigned r;
        r = 1 % m;
        x = x % m;
        while (e != 0) begin
            if (e[0]) r = mulmod(r, x, m);
            x = mulmod(x, x, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_answer solve_dlog(logic [31:0] base_v, logic [31:0] tgt_v,
                                           logic [31:0] mod_v);
        longint unsigned a, b, m, g, k, q, w, p, shift, fix;
        longint unsigned baby_step[longint unsigned];
        t_answer res;
        a = base_v;
        b = tgt_v;
        m = mod_v;
        shift = 0;
        fix = 1;
        res.found = 0;
        res.log_v = '0;
        if (m == 0) return res;
        a = a % m;
        b = b % m;
        if (b == 1) begin
            res.found = 1;
            return res;
        end
        // strip common factors of base and modulus
        g = gcd64(a, m);
        while (g != 1) begin
            if (b % g != 0) return res;
            m = m / g;
            b = b / g;
            fix = mulmod(fix, a / g, m);
            shift++;
            if (b == fix) begin
                res.found = 1;
                res.log_v = shift[32:0];
                return res;
            end
            g = gcd64(a, m);
        end
        a = a % m;
        k = longint'($sqrt(real'(m)));
        while (k > 0 && k * k > m) k--;
        while (k * k < m) k++;
        // baby steps: a repeated key keeps the later step
        q = b;
        for (longint unsigned j = 0; j < k; j++) begin
            baby_step[q] = j;
            q = mulmod(q, a, m);
        end
        w = powmod(a, k, m);
        p = mulmod(w, fix, m);
        for (longint unsigned i = 1; i <= k; i++) begin
            if (baby_step.exists(p)) begin
                res.found = 1;
                res.log_v = 33'(i * k - baby_step[p] + shift);
                return res;
            end
            p = mulmod(p, w, m);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Query source
    // ------------------------------------------------------------------
    task automatic send_query(t_query qr);
        t_answer ans;
        int gap;
        if (qr.typed) begin
            ans.found = qr.found;
            ans.log_v = qr.log_v;
        end else begin
            ans = solve_dlog(qr.base_v, qr.tgt_v, qr.mod_v);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {qr.mod_v, qr.tgt_v, qr.base_v};
        do @(posedge i_clk); while (!o_s_tready);
        pending_logs.push_back(ans);
        // mostly short gaps, now and then a long one, often none at all
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_query directed[$];
        t_query qr;
        int sel;
        // mostly typed rows: target one, modulus one, all ones, early no-solution
        directed.push_back('{32'd7, 32'd1, 32'd13, 1, 1, 33'd0});
        directed.push_back('{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1, 1, 33'd0});
        directed.push_back('{32'd5, 32'd9, 32'd1, 1, 1, 33'd1});
        directed.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1, 1, 33'd1});
        directed.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 33'd1});
        directed.push_back('{32'd0, 32'd0, 32'hFFFF_FFFF, 1, 1, 33'd1});
        directed.push_back('{32'd2, 32'd3, 32'h8000_0000, 1, 0, 33'd0});
        directed.push_back('{32'd0, 32'd5, 32'd7, 1, 0, 33'd0});
        directed.push_back('{32'd0, 32'd0, 32'd0, 0, 0, 33'd0});
        directed[$].mod_v = 32'd1;
        // predicted rows: ordinary solves, gcd chains, no-solution searches
        directed.push_back('{32'd3, 32'd13, 32'd17, 0, 0, 33'd0});
        directed.push_back('{32'd2, 32'd0, 32'd1024, 0, 0, 33'd0});
        directed.push_back('{32'd6, 32'd4, 32'd100, 0, 0, 33'd0});
        directed.push_back('{32'd4, 32'd3, 32'd7, 0, 0, 33'd0});
        directed.push_back('{32'd1, 32'd2, 32'd4093, 0, 0, 33'd0});
        directed.push_back('{32'd0, 32'd0, 32'd4096, 0, 0, 33'd0});
        directed.push_back('{32'h8000_0001, 32'h7FFF_FFFF, 32'd4091, 0, 0, 33'd0});
        directed.push_back('{32'd5, 32'd3, 32'd65521, 0, 0, 33'd0});
        directed.push_back('{32'd12, 32'd36, 32'd360, 0, 0, 33'd0});

        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) send_query(directed[n]);

        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 9);
            qr.base_v = $urandom;
            qr.tgt_v  = $urandom;
            qr.typed  = 0;
            qr.found  = 0;
            qr.log_v  = '0;
            if (sel < 7) begin
                qr.mod_v = $urandom_range(1, 4096);
            end else if (sel < 8) begin
                qr.mod_v = $urandom_range(4097, 65536);
            end else if (sel < 9) begin
                // large modulus, target one: answered at once
                qr.mod_v = $urandom | 32'h2;
                qr.tgt_v = 32'd1;
            end else begin
                // base equal to a large modulus: gcd strip exits early
                qr.mod_v = $urandom | 32'h8000_0000;
                qr.base_v = qr.mod_v;
            end
            // keep the solved cases common: build a target from a real power
            if (sel < 8 && $urandom_range(0, 2) != 0)
                qr.tgt_v = 32'(powmod(qr.base_v, $urandom_range(0, 5000), qr.mod_v));
            send_query(qr);
        end
        i_s_tvalid <= 1'b0;
        send_done = 1;
    end

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------
    initial begin
        int hold_cnt;
        t_answer want;
        hold_cnt = 3000;   // long hold-off once the first result shows: back up the input
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (!o_m_tvalid) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                if (pending_logs.size() == 0) begin
                    $display("%0t: unexpected result found=%0b log=%0d",
                             $time, o_m_tuser[0], o_m_tdata[32:0]);
                    fail_cnt++;
                end else begin
                    want = pending_logs.pop_front();
                    if (o_m_tuser[0] !== want.found) begin
                        $display("%0t: found mismatch, expected %0b actual %0b",
                                 $time, want.found, o_m_tuser[0]);
                        fail_cnt++;
                    end
                    if (o_m_tdata[32:0] !== want.log_v) begin
                        $display("%0t: log mismatch, expected %0d actual %0d",
                                 $time, want.log_v, o_m_tdata[32:0]);
                        fail_cnt++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(1, 3);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------
    initial begin
        wait (send_done);
        while (pending_logs.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ebsgs_pkg.sv
hw/rtl/ebsgs_div.sv
hw/rtl/ebsgs_store.sv
hw/rtl/extended_bsgs_discrete_log.sv
tb/tb.sv
